FILE: design/emi_pkg.sv
// ----------------------------------------------------------------------------
// emi_pkg
// Shared types and constants of the eased motion interpolator.
// ----------------------------------------------------------------------------
package emi_pkg;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_START_X    = 3'd0;
  localparam logic [2:0] REG_START_Y    = 3'd1;
  localparam logic [2:0] REG_END_X      = 3'd2;
  localparam logic [2:0] REG_END_Y      = 3'd3;
  localparam logic [2:0] REG_DURATION   = 3'd4;
  localparam logic [2:0] REG_EASE_MODE  = 3'd5;
  localparam logic [2:0] REG_HOP_HEIGHT = 3'd6;

  typedef enum logic [1:0] {
    EASE_LINEAR,
    EASE_IN,
    EASE_OUT,
    EASE_BOUNCE
  } ease_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [15:0]        duration;
    ease_t              ease_mode;
    logic [14:0]        hop_height;
  } cfg_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [15:0] elapsed;
    logic        active;
    logic        ended;
  } job_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               running;
    logic               ended;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EASE,
    ST_PQ,
    ST_HOP,
    ST_X,
    ST_Y,
    ST_OUT
  } back_state_t;

endpackage

FILE: design/emi_if.sv
// ----------------------------------------------------------------------------
// emi_if
// Valid/ready channels of the interpolator: command items in, positions out.
// ----------------------------------------------------------------------------
interface emi_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] delta_ms;

  modport source (output valid, cmd, delta_ms, input ready);
  modport sink   (input valid, cmd, delta_ms, output ready);
endinterface

interface emi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               running;
  logic               ended;

  modport source (output valid, pos_x, pos_y, running, ended, input ready);
  modport sink   (input valid, pos_x, pos_y, running, ended, output ready);
endinterface

FILE: design/eased_motion_interpolator_unit.sv
// ----------------------------------------------------------------------------
// eased_motion_interpolator_unit
// Sprite tween engine: eased x/y interpolation with a parabolic hop.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Carries
//  -------  ---------  ------------------  --------------------------------
//  in_ch    in         valid/ready         cmd, delta_ms
//  out_ch   out        valid/ready         pos_x, pos_y, running, ended
//  APB      in/out     psel/penable/pready 7 registers at byte address 4*i
//
//  When the tween is running, a job that reaches the back end passes the
//  serial progress divider and then the ease, product, hop, x, y and
//  output states; when progress is pinned at one it skips the divider.
//  The back end takes no new job until its result is in the output register.
//  Reset is synchronous and active low; it clears the tween state, the
//  registers, the job queue and the output valid.
//  The front takes an item in the cycle it is offered while the job queue
//  has room, so a waiting result does not block new input transfers.
//
// The front end applies each command to the elapsed time and armed flag at
// once, so the job it queues already carries the state after the item. The
// back end only needs the configuration, which the user must write only while the block is
// idle; the block itself does not enforce this, and then it is steady while jobs are in flight.
// ----------------------------------------------------------------------------
module eased_motion_interpolator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  emi_in_if.sink                     in_ch,
  emi_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [emi_pkg::ADDR_W-1:0] paddr,
  input  logic [emi_pkg::DATA_W-1:0] pwdata,
  output logic [emi_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import emi_pkg::*;

  cfg_t cfg;
  job_t push_job;
  job_t pop_job;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;

  // Configuration registers on the APB port.
  emi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end: takes commands and tracks elapsed time and the armed flag.
  emi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .duration (cfg.duration),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_job)
  );

  // Job queue that lets the front and the back stall independently.
  emi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_job)
  );

  // Back end: progress division, easing, hop and interpolation.
  emi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (q_not_empty),
    .job       (pop_job),
    .job_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: design/emi_cfg.sv
// ----------------------------------------------------------------------------
// emi_cfg
// APB register file holding the tween endpoints, duration, curve and hop.
// ----------------------------------------------------------------------------
module emi_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [emi_pkg::ADDR_W-1:0] paddr,
  input  logic [emi_pkg::DATA_W-1:0] pwdata,
  output logic [emi_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output emi_pkg::cfg_t              cfg
);
  import emi_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_X:    cfg_nxt.start_x    = pwdata[15:0];
        REG_START_Y:    cfg_nxt.start_y    = pwdata[15:0];
        REG_END_X:      cfg_nxt.end_x      = pwdata[15:0];
        REG_END_Y:      cfg_nxt.end_y      = pwdata[15:0];
        REG_DURATION:   cfg_nxt.duration   = pwdata[15:0];
        REG_EASE_MODE:  cfg_nxt.ease_mode  = ease_t'(pwdata[1:0]);
        REG_HOP_HEIGHT: cfg_nxt.hop_height = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X:    prdata = {16'h0, cfg_r.start_x};
      REG_START_Y:    prdata = {16'h0, cfg_r.start_y};
      REG_END_X:      prdata = {16'h0, cfg_r.end_x};
      REG_END_Y:      prdata = {16'h0, cfg_r.end_y};
      REG_DURATION:   prdata = {16'h0, cfg_r.duration};
      REG_EASE_MODE:  prdata = {30'h0, cfg_r.ease_mode};
      REG_HOP_HEIGHT: prdata = {17'h0, cfg_r.hop_height};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/emi_front.sv
// ----------------------------------------------------------------------------
// emi_front
// Accepts commands, advances elapsed time and the armed flag, and queues
// one job per item for the back end.
// ----------------------------------------------------------------------------
module emi_front (
  input  logic          clk,
  input  logic          rst_n,
  emi_in_if.sink        in_ch,
  input  logic [15:0]   duration,
  input  logic          q_full,
  output logic          q_push,
  output emi_pkg::job_t q_data
);
  import emi_pkg::*;

  logic [15:0] elapsed_r, elapsed_nxt;
  logic        active_r, active_nxt;
  logic        ended;
  logic [16:0] sum;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign sum         = {1'b0, elapsed_r} + {1'b0, in_ch.delta_ms};

  always_comb begin
    elapsed_nxt = elapsed_r;
    active_nxt  = active_r;
    ended       = 1'b0;
    if (in_ch.cmd) begin
      elapsed_nxt = '0;
      active_nxt  = 1'b1;
    end else if (active_r) begin
      if (sum >= {1'b0, duration}) begin
        elapsed_nxt = duration;
        active_nxt  = 1'b0;
        ended       = 1'b1;
      end else begin
        elapsed_nxt = sum[15:0];
      end
    end
  end

  assign q_data = '{elapsed: elapsed_nxt, active: active_nxt, ended: ended};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      active_r  <= 1'b0;
    end else if (q_push) begin
      elapsed_r <= elapsed_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

FILE: design/emi_queue.sv
// ----------------------------------------------------------------------------
// emi_queue
// Short FIFO of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module emi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  emi_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output emi_pkg::job_t pop_data
);
  import emi_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  job_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/emi_back.sv
// ----------------------------------------------------------------------------
// emi_back
// Sequencer that turns one job into a position: serial divider for progress,
// then one shared multiplier for the curve, the hop arc and both lerps.
// ----------------------------------------------------------------------------
module emi_back (
  input  logic          clk,
  input  logic          rst_n,
  input  emi_pkg::cfg_t cfg,
  input  logic          job_valid,
  input  emi_pkg::job_t job,
  output logic          job_pop,
  emi_out_if.source     out_ch
);
  import emi_pkg::*;

  localparam logic [19:0] SEG1_LIM = 20'd262144;   // 4.0 in 11p units
  localparam logic [19:0] SEG2_LIM = 20'd524288;   // 8.0
  localparam logic [19:0] SEG3_LIM = 20'd655360;   // 10.0
  localparam logic signed [21:0] SEG1_CTR = 22'sd393216;
  localparam logic signed [21:0] SEG2_CTR = 22'sd589824;
  localparam logic signed [21:0] SEG3_CTR = 22'sd1376256;
  localparam logic [17:0] OFS1 = 18'd49152;
  localparam logic [17:0] OFS2 = 18'd61440;
  localparam logic [17:0] OFS3 = 18'd64512;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  back_state_t        state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        quo_r, quo_nxt;
  logic [16:0]        p_r, p_nxt;
  logic [1:0]         seg_r, seg_nxt;
  logic [16:0]        e_r, e_nxt;
  logic [15:0]        hop_r, hop_nxt;
  logic signed [17:0] x_r, x_nxt;
  job_t               job_r, job_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic signed [19:0] mult_a;
  logic signed [31:0] mult_b;
  logic signed [51:0] prod_nxt, prod_r;

  logic [16:0]        div_t;
  logic               div_ge;
  logic [16:0]        div_diff;
  logic               force_one;

  logic [19:0]        s_w;
  logic [1:0]         seg_c;
  logic signed [21:0] bd;
  logic [21:0]        bd_mag;
  logic [18:0]        sq_op;
  logic [16:0]        one_minus_p;

  logic [32:0]        rnd16;
  logic [36:0]        rnd20;
  logic [32:0]        rnd22;
  logic [17:0]        bounce_sum;
  logic [16:0]        e_calc;

  logic signed [51:0] lerp_sum;
  logic signed [17:0] lerp_q;
  logic signed [51:0] hop_sum;
  logic signed [17:0] y_lerp;
  logic signed [18:0] y_full;

  assign div_t     = {rem_r, 1'b0};
  assign div_ge    = div_t >= {1'b0, cfg.duration};
  assign div_diff  = div_t - {1'b0, cfg.duration};
  assign force_one = !job.active || (cfg.duration == '0) || (job.elapsed >= cfg.duration);

  assign one_minus_p = ONE_Q16 - p_r;
  assign s_w         = {3'b0, p_r} * 20'd11;

  always_comb begin
    if (s_w < SEG1_LIM) begin
      seg_c = 2'd0;
      bd    = $signed({2'b0, s_w});
    end else if (s_w < SEG2_LIM) begin
      seg_c = 2'd1;
      bd    = $signed({2'b0, s_w}) - SEG1_CTR;
    end else if (s_w < SEG3_LIM) begin
      seg_c = 2'd2;
      bd    = $signed({2'b0, s_w}) - SEG2_CTR;
    end else begin
      seg_c = 2'd3;
      bd    = $signed({1'b0, s_w, 1'b0}) - SEG3_CTR;
    end
    bd_mag = bd[21] ? 22'(-bd) : 22'(bd);
  end

  always_comb begin
    case (cfg.ease_mode)
      EASE_OUT:    sq_op = {2'b0, one_minus_p};
      EASE_BOUNCE: sq_op = bd_mag[18:0];
      default:     sq_op = {2'b0, p_r};
    endcase
  end

  // Curve value from the registered square.
  assign rnd16 = prod_r[32:0] + 33'd32768;
  assign rnd20 = prod_r[36:0] + 37'd524288;
  assign rnd22 = prod_r[32:0] + 33'd2097152;

  always_comb begin
    case (seg_r)
      2'd0:    bounce_sum = {1'b0, rnd20[36:20]};
      2'd1:    bounce_sum = {1'b0, rnd20[36:20]} + OFS1;
      2'd2:    bounce_sum = {1'b0, rnd20[36:20]} + OFS2;
      default: bounce_sum = {7'b0, rnd22[32:22]} + OFS3;
    endcase
    case (cfg.ease_mode)
      EASE_IN:     e_calc = rnd16[32:16];
      EASE_OUT:    e_calc = ONE_Q16 - rnd16[32:16];
      EASE_BOUNCE: e_calc = (bounce_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : bounce_sum[16:0];
      default:     e_calc = p_r;
    endcase
  end

  assign lerp_sum = prod_r + 52'sd32768;
  assign lerp_q   = lerp_sum[33:16];
  assign hop_sum  = prod_r + 52'sd536870912;
  assign y_lerp   = $signed({{2{cfg.start_y[15]}}, cfg.start_y}) + lerp_q;
  assign y_full   = $signed({y_lerp[17], y_lerp}) - $signed({3'b0, hop_r});

  assign prod_nxt = mult_a * mult_b;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    p_nxt         = p_r;
    seg_nxt       = seg_r;
    e_nxt         = e_r;
    hop_nxt       = hop_r;
    x_nxt         = x_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    job_pop       = 1'b0;
    mult_a        = '0;
    mult_b        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          job_nxt = job;
          if (force_one) begin
            p_nxt     = ONE_Q16;
            state_nxt = ST_EASE;
          end else begin
            rem_nxt   = job.elapsed;
            quo_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[15:0] : div_t[15:0];
        quo_nxt = {quo_r[14:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) begin
          p_nxt     = {1'b0, quo_r[14:0], div_ge};
          state_nxt = ST_EASE;
        end
      end
      ST_EASE: begin
        seg_nxt   = seg_c;
        mult_a    = $signed({1'b0, sq_op});
        mult_b    = $signed({13'b0, sq_op});
        state_nxt = ST_PQ;
      end
      ST_PQ: begin
        e_nxt     = e_calc;
        mult_a    = $signed({3'b0, p_r});
        mult_b    = $signed({15'b0, one_minus_p});
        state_nxt = ST_HOP;
      end
      ST_HOP: begin
        mult_a    = $signed({5'b0, cfg.hop_height});
        mult_b    = $signed({1'b0, prod_r[30:0]});
        state_nxt = ST_X;
      end
      ST_X: begin
        hop_nxt   = hop_sum[45:30];
        mult_a    = 20'(($signed({cfg.end_x[15], cfg.end_x})
                         - $signed({cfg.start_x[15], cfg.start_x})));
        mult_b    = $signed({15'b0, e_r});
        state_nxt = ST_Y;
      end
      ST_Y: begin
        x_nxt     = $signed({{2{cfg.start_x[15]}}, cfg.start_x}) + lerp_q;
        mult_a    = 20'(($signed({cfg.end_y[15], cfg.end_y})
                         - $signed({cfg.start_y[15], cfg.start_y})));
        mult_b    = $signed({15'b0, e_r});
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.pos_x   = sat16($signed({x_r[17], x_r}));
          out_data_nxt.pos_y   = sat16(y_full);
          out_data_nxt.running = job_r.active;
          out_data_nxt.ended   = job_r.ended;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    p_r        <= p_nxt;
    seg_r      <= seg_nxt;
    e_r        <= e_nxt;
    hop_r      <= hop_nxt;
    x_r        <= x_nxt;
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
    // The y lerp is still formed from the product while the finished
    // position waits for the output register, so it is held there.
    if (state_r != ST_OUT) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = out_data_r.pos_x;
  assign out_ch.pos_y   = out_data_r.pos_y;
  assign out_ch.running = out_data_r.running;
  assign out_ch.ended   = out_data_r.ended;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("finished position was not loaded into the output register");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == ST_IDLE && job_valid))
    else $error("job taken from the queue outside the idle state");

  a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EASE) |-> (p_r <= ONE_Q16))
    else $error("progress exceeds one");

  a_end_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.ended) |-> !out_data_r.running)
    else $error("finishing item reports the tween still running");

endmodule
